// ===== src/kmc_pkg.sv =====
// ---------------------------------------------------------------------------
// kmc_pkg: shared types and constants for the 4-D k-means cluster block
// Request/result payload structs, command/status codes, FSM state type.
// ---------------------------------------------------------------------------
`default_nettype none
package kmc_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int COORD_BITS_DEF   = 16;
    localparam int CFG_IDX_BITS     = 1;
    localparam int CFG_DATA_BITS    = 8;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CLUSTERS   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITERATIONS = 1'b1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SEED  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SEED = 2'd2;
    localparam logic [1:0] ST_UNSEEDED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] from_x;
        logic [15:0] from_y;
        logic [15:0] to_x;
        logic [15:0] to_y;
        logic [5:0]  seed_index;
    } req_t;

    typedef struct packed {
        logic [5:0] point_index;
        logic [2:0] group_id;
        logic [7:0] passes_used;
        logic [1:0] status;
        logic       last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_RD,
        S_ASN_RD,
        S_ASN_CMP,
        S_ASN_WR,
        S_ACC_RD,
        S_ACC_ADD,
        S_DIV_GO,
        S_DIV,
        S_DIV_WR,
        S_OUT_RD,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== src/kmeans_cluster_4d_top.sv =====
// ---------------------------------------------------------------------------
// kmeans_cluster_4d_top: Lloyd k-means over 4-D pickup/delivery points
// Point, center and assignment memories with a sequencing FSM.
// ---------------------------------------------------------------------------
// Add and clear requests load their result the cycle they are accepted; a
// seed request that stores a center loads it in the next cycle, once the
// seed point is read. A new request is taken when the block is idle and the
// result register is free. A run works from a single-port point memory: per
// pass, the assign sweep does one center read and one compare per center
// through one squared-distance unit and then writes the point's assignment,
// the accumulate sweep reads and adds each point, and the update divides the
// four SUM_BITS-wide sums of each non-empty cluster with a bit-serial divider,
// skipping empty ones (SUM_BITS = COORD_BITS + clog2(MAX_POINTS + 1)). Results
// then stream one per loaded point; each waits in the output register until taken.
`default_nettype none
module kmeans_cluster_4d_top #(
    parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
    parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
    parameter int COORD_BITS   = kmc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire kmc_pkg::req_t                       req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output kmc_pkg::rsp_t                            rsp,
    input  wire logic                                cfg_we,
    input  wire logic [kmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [kmc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    localparam int PI_BITS  = $clog2(MAX_POINTS);
    localparam int PC_BITS  = $clog2(MAX_POINTS + 1);
    localparam int CI_BITS  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CC_BITS  = $clog2(MAX_CLUSTERS + 1);
    localparam int SUM_BITS = COORD_BITS + PC_BITS;
    localparam int DIST_BITS = 2 * COORD_BITS + 2;
    localparam int PW       = 4 * COORD_BITS;

    typedef logic [3:0][COORD_BITS-1:0] vec_t;
    typedef logic [3:0][SUM_BITS-1:0]   svec_t;

    // memories
    vec_t                 pmem [MAX_POINTS];
    logic [CI_BITS-1:0]   amem [MAX_POINTS];
    vec_t                 cmem [MAX_CLUSTERS];
    vec_t                 prd_reg;
    logic [CI_BITS-1:0]   ard_reg;
    vec_t                 crd_reg;

    logic                 p_we, a_we, c_we;
    logic [PI_BITS-1:0]   p_addr;
    vec_t                 p_wd;
    logic [PI_BITS-1:0]   a_addr;
    logic [CI_BITS-1:0]   a_wd;
    logic [CI_BITS-1:0]   c_addr;
    vec_t                 c_wd;

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_addr] <= p_wd;
        prd_reg <= pmem[p_addr];
        if (a_we)
            amem[a_addr] <= a_wd;
        ard_reg <= amem[a_addr];
        if (c_we)
            cmem[c_addr] <= c_wd;
        crd_reg <= cmem[c_addr];
    end

    // registers
    kmc_pkg::state_t      state_reg, state_next;
    logic [3:0]           ncl_reg;
    logic [7:0]           mit_reg;
    logic [PC_BITS-1:0]   pcnt_reg, pcnt_next;
    logic [CC_BITS-1:0]   scnt_reg, scnt_next;
    logic [PI_BITS-1:0]   pidx_reg, pidx_next;
    logic [CC_BITS-1:0]   cidx_reg, cidx_next;
    logic [CI_BITS-1:0]   best_reg, best_next;
    logic [DIST_BITS-1:0] bestd_reg, bestd_next;
    logic [7:0]           pass_reg, pass_next;
    logic                 chg_reg, chg_next;
    logic [1:0]           dim_reg, dim_next;
    svec_t                sums_reg [MAX_CLUSTERS];
    logic [PC_BITS-1:0]   cnts_reg [MAX_CLUSTERS];
    logic                 clr_acc, acc_en;
    vec_t                 newc_reg, newc_next;
    logic                 ov_reg, ov_next;
    kmc_pkg::rsp_t        rsp_reg, rsp_next;
    logic [PI_BITS-1:0]   seed_reg, seed_next;

    logic [CC_BITS-1:0]   k_eff;
    logic [7:0]           limit;
    logic [CI_BITS-1:0]   cslot;

    always_comb
    begin
        if (ncl_reg == 4'd0)
            k_eff = CC_BITS'(1);
        else if (32'(ncl_reg) > MAX_CLUSTERS)
            k_eff = CC_BITS'(MAX_CLUSTERS);
        else
            k_eff = CC_BITS'(ncl_reg);
        limit = (mit_reg == 8'd0) ? 8'd1 : mit_reg;
        cslot = cidx_reg[CI_BITS-1:0];
    end

    // squared distance of registered point and center reads
    logic [DIST_BITS-1:0] sqd;
    always_comb
    begin
        logic [COORD_BITS-1:0]   df;
        logic [2*COORD_BITS-1:0] sq;
        sqd = '0;
        for (int d = 0; d < 4; d++)
        begin
            df = (prd_reg[d] > crd_reg[d]) ? prd_reg[d] - crd_reg[d]
                                           : crd_reg[d] - prd_reg[d];
            sq  = df * df;
            sqd = sqd + DIST_BITS'(sq);
        end
    end

    // divider
    logic                 div_start, div_done;
    logic [SUM_BITS-1:0]  div_q;
    logic [SUM_BITS-1:0]  div_num;
    always_comb
    begin
        div_num = sums_reg[cslot][dim_reg];
    end
    kmc_div #(.NUM_BITS(SUM_BITS), .DEN_BITS(PC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cnts_reg[cslot]),
        .done  (div_done),
        .quot  (div_q)
    );

    // accumulators
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            if (clr_acc)
            begin
                sums_reg[c] <= '0;
                cnts_reg[c] <= '0;
            end
            else if (acc_en && (32'(ard_reg) == c))
            begin
                for (int d = 0; d < 4; d++)
                    sums_reg[c][d] <= sums_reg[c][d] + SUM_BITS'(prd_reg[d]);
                cnts_reg[c] <= cnts_reg[c] + 1'b1;
            end
        end
    end

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncl_reg <= 4'd2;
            mit_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kmc_pkg::REG_NUM_CLUSTERS:   ncl_reg <= cfg_data[3:0];
                kmc_pkg::REG_MAX_ITERATIONS: mit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic req_fire, out_free;
    assign out_free  = !rsp_valid || rsp_ready;
    assign req_ready = (state_reg == kmc_pkg::S_IDLE) && out_free;
    assign req_fire  = req_valid && req_ready;

    function automatic kmc_pkg::rsp_t mk(input logic [5:0] pi, input logic [2:0] ci,
                                         input logic [7:0] ps, input logic [1:0] st,
                                         input logic lst);
        kmc_pkg::rsp_t r;
        r.point_index = pi;
        r.group_id    = ci;
        r.passes_used = ps;
        r.status      = st;
        r.last        = lst;
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kmc_pkg::S_IDLE:
                if (req_fire)
                begin
                    if (req.cmd == kmc_pkg::CMD_SEED && 32'(req.seed_index) < 32'(pcnt_reg)
                        && 32'(scnt_reg) < MAX_CLUSTERS)
                        state_next = kmc_pkg::S_SEED_RD;
                    else if (req.cmd == kmc_pkg::CMD_RUN && scnt_reg >= k_eff
                             && pcnt_reg != '0)
                        state_next = kmc_pkg::S_ASN_RD;
                end
            kmc_pkg::S_SEED_RD:
                if (out_free)
                    state_next = kmc_pkg::S_IDLE;
            kmc_pkg::S_ASN_RD:  state_next = kmc_pkg::S_ASN_CMP;
            kmc_pkg::S_ASN_CMP:
                if (cidx_reg + 1'b1 >= k_eff)
                    state_next = kmc_pkg::S_ASN_WR;
                else
                    state_next = kmc_pkg::S_ASN_RD;
            kmc_pkg::S_ASN_WR:
                if (32'(pidx_reg) + 1 >= 32'(pcnt_reg))
                    state_next = kmc_pkg::S_ACC_RD;
                else
                    state_next = kmc_pkg::S_ASN_RD;
            kmc_pkg::S_ACC_RD:  state_next = kmc_pkg::S_ACC_ADD;
            kmc_pkg::S_ACC_ADD:
                if (32'(pidx_reg) + 1 >= 32'(pcnt_reg))
                    state_next = kmc_pkg::S_DIV_GO;
                else
                    state_next = kmc_pkg::S_ACC_RD;
            kmc_pkg::S_DIV_GO:
                if (cnts_reg[cslot] == '0)
                    state_next = (cidx_reg + 1'b1 >= k_eff) ? kmc_pkg::S_DIV_WR
                                                           : kmc_pkg::S_DIV_GO;
                else
                    state_next = kmc_pkg::S_DIV;
            kmc_pkg::S_DIV:
                if (div_done)
                    state_next = (dim_reg == 2'd3) ? kmc_pkg::S_DIV_WR : kmc_pkg::S_DIV_GO;
            kmc_pkg::S_DIV_WR:
                if (cidx_reg + 1'b1 >= k_eff || cnts_reg[cslot] == '0)
                    state_next = (chg_reg && pass_reg < limit) ? kmc_pkg::S_ASN_RD
                                                               : kmc_pkg::S_OUT_RD;
                else
                    state_next = kmc_pkg::S_DIV_GO;
            kmc_pkg::S_OUT_RD:  state_next = kmc_pkg::S_OUT;
            kmc_pkg::S_OUT:
                if (out_free)
                    state_next = (32'(pidx_reg) + 1 >= 32'(pcnt_reg)) ? kmc_pkg::S_IDLE
                                                                      : kmc_pkg::S_OUT_RD;
            default: state_next = kmc_pkg::S_IDLE;
        endcase
    end

    // outputs / datapath
    always_comb
    begin
        pcnt_next  = pcnt_reg;
        scnt_next  = scnt_reg;
        pidx_next  = pidx_reg;
        cidx_next  = cidx_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        pass_next  = pass_reg;
        chg_next   = chg_reg;
        dim_next   = dim_reg;
        newc_next  = newc_reg;
        ov_next    = ov_reg;
        rsp_next   = rsp_reg;
        seed_next  = seed_reg;
        p_we = 1'b0; a_we = 1'b0; c_we = 1'b0;
        p_addr = pidx_reg; p_wd = prd_reg;
        a_addr = pidx_reg; a_wd = best_reg;
        c_addr = cslot;    c_wd = newc_reg;
        clr_acc = 1'b0; acc_en = 1'b0; div_start = 1'b0;
        if (ov_reg && rsp_ready)
            ov_next = 1'b0;
        case (state_reg)
            kmc_pkg::S_IDLE:
                if (req_fire)
                begin
                    ov_next = 1'b1;
                    case (req.cmd)
                        kmc_pkg::CMD_ADD:
                            if (32'(pcnt_reg) >= MAX_POINTS)
                                rsp_next = mk(6'd0, 3'd0, 8'd0, kmc_pkg::ST_FULL, 1'b1);
                            else
                            begin
                                p_we   = 1'b1;
                                p_addr = pcnt_reg[PI_BITS-1:0];
                                p_wd   = {req.to_y[COORD_BITS-1:0], req.to_x[COORD_BITS-1:0],
                                          req.from_y[COORD_BITS-1:0],
                                          req.from_x[COORD_BITS-1:0]};
                                rsp_next = mk(6'(pcnt_reg), 3'd0, 8'd0, kmc_pkg::ST_OK, 1'b1);
                                pcnt_next = pcnt_reg + 1'b1;
                            end
                        kmc_pkg::CMD_SEED:
                            if (32'(req.seed_index) >= 32'(pcnt_reg))
                                rsp_next = mk(req.seed_index, 3'd0, 8'd0,
                                              kmc_pkg::ST_BAD_SEED, 1'b1);
                            else if (32'(scnt_reg) >= MAX_CLUSTERS)
                                rsp_next = mk(req.seed_index, 3'd0, 8'd0, kmc_pkg::ST_OK, 1'b1);
                            else
                            begin
                                ov_next   = 1'b0;
                                p_addr    = req.seed_index[PI_BITS-1:0];
                                seed_next = req.seed_index[PI_BITS-1:0];
                            end
                        kmc_pkg::CMD_RUN:
                            if (scnt_reg < k_eff)
                                rsp_next = mk(6'd0, 3'd0, 8'd0, kmc_pkg::ST_UNSEEDED, 1'b1);
                            else if (pcnt_reg == '0)
                                rsp_next = mk(6'd0, 3'd0, 8'd0, kmc_pkg::ST_OK, 1'b1);
                            else
                            begin
                                ov_next   = 1'b0;
                                pidx_next = '0;
                                cidx_next = '0;
                                pass_next = 8'd1;
                                chg_next  = 1'b0;
                            end
                        default:
                        begin
                            pcnt_next = '0;
                            scnt_next = '0;
                            rsp_next  = mk(6'd0, 3'd0, 8'd0, kmc_pkg::ST_OK, 1'b1);
                        end
                    endcase
                end
            kmc_pkg::S_SEED_RD:
                if (out_free)
                begin
                    c_we   = 1'b1;
                    c_addr = scnt_reg[CI_BITS-1:0];
                    c_wd   = prd_reg;
                    rsp_next = mk(6'(seed_reg), 3'(scnt_reg), 8'd0, kmc_pkg::ST_OK, 1'b1);
                    ov_next  = 1'b1;
                    scnt_next = scnt_reg + 1'b1;
                end
            kmc_pkg::S_ASN_RD:
            begin
                p_addr = pidx_reg;
                a_addr = pidx_reg;
                c_addr = cslot;
            end
            kmc_pkg::S_ASN_CMP:
            begin
                if (cidx_reg == '0 || sqd < bestd_reg)
                begin
                    bestd_next = sqd;
                    best_next  = cslot;
                end
                cidx_next = cidx_reg + 1'b1;
            end
            kmc_pkg::S_ASN_WR:
            begin
                a_we = 1'b1;
                a_wd = best_reg;
                if (pass_reg == 8'd1 || ard_reg != best_reg)
                    chg_next = 1'b1;
                cidx_next = '0;
                if (32'(pidx_reg) + 1 >= 32'(pcnt_reg))
                begin
                    pidx_next = '0;
                    clr_acc   = 1'b1;
                end
                else
                    pidx_next = pidx_reg + 1'b1;
            end
            kmc_pkg::S_ACC_RD: ;
            kmc_pkg::S_ACC_ADD:
            begin
                acc_en = 1'b1;
                if (32'(pidx_reg) + 1 >= 32'(pcnt_reg))
                begin
                    pidx_next = '0;
                    cidx_next = '0;
                    dim_next  = 2'd0;
                end
                else
                    pidx_next = pidx_reg + 1'b1;
            end
            kmc_pkg::S_DIV_GO:
                if (cnts_reg[cslot] == '0)
                begin
                    if (cidx_reg + 1'b1 < k_eff)
                        cidx_next = cidx_reg + 1'b1;
                end
                else
                    div_start = 1'b1;
            kmc_pkg::S_DIV:
                if (div_done)
                begin
                    newc_next[dim_reg] = div_q[COORD_BITS-1:0];
                    dim_next = dim_reg + 1'b1;
                end
            kmc_pkg::S_DIV_WR:
            begin
                if (cnts_reg[cslot] != '0)
                    c_we = 1'b1;
                dim_next = 2'd0;
                if (cidx_reg + 1'b1 >= k_eff || cnts_reg[cslot] == '0)
                begin
                    cidx_next = '0;
                    pidx_next = '0;
                    if (chg_reg && pass_reg < limit)
                    begin
                        pass_next = pass_reg + 1'b1;
                        chg_next  = 1'b0;
                    end
                end
                else
                    cidx_next = cidx_reg + 1'b1;
            end
            kmc_pkg::S_OUT_RD:
                a_addr = pidx_reg;
            kmc_pkg::S_OUT:
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    rsp_next = mk(6'(pidx_reg), 3'(ard_reg), pass_reg, kmc_pkg::ST_OK,
                                  32'(pidx_reg) + 1 >= 32'(pcnt_reg));
                    pidx_next = pidx_reg + 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmc_pkg::S_IDLE;
            pcnt_reg  <= '0;
            scnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            scnt_reg  <= scnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        cidx_reg  <= cidx_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        pass_reg  <= pass_next;
        chg_reg   <= chg_next;
        dim_reg   <= dim_next;
        newc_reg  <= newc_next;
        rsp_reg   <= rsp_next;
        seed_reg  <= seed_next;
    end

    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcnt_reg) <= MAX_POINTS) else $error("point count overflow");
    a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scnt_reg) <= MAX_CLUSTERS) else $error("seed count overflow");
    a_busy_noreq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kmc_pkg::S_IDLE) |-> !req_ready) else $error("ready while busy");
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmc_pkg::S_OUT) |-> (pass_reg >= 8'd1 && pass_reg <= limit))
        else $error("pass count out of range");
endmodule
`default_nettype wire

// ===== src/kmc_div.sv =====
// ---------------------------------------------------------------------------
// kmc_div: restoring divider, one quotient bit per cycle
// Unsigned sum / count for the center update.
// ---------------------------------------------------------------------------
`default_nettype none
module kmc_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 7
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS+1:0] trial;
    logic [DEN_BITS:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        trial     = {1'b0, shifted} - {2'b00, d_reg};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_BITS+1])
            begin
                r_next = trial[DEN_BITS:0];
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_BITS'(1));
    assign quot = q_next;
endmodule
`default_nettype wire

// ===== tb/kmeans_cluster_4d_top_test.sv =====
// ---------------------------------------------------------------------------
// kmeans_cluster_4d_top_test: self-checking bench for the 4-D k-means block
// Sends add, seed, run and clear requests under random valid/ready idling and
// checks every result against an in-bench k-means predictor. Configuration
// is changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module kmeans_cluster_4d_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS      = kmc_pkg::MAX_POINTS_DEF;
    localparam int NCTR      = kmc_pkg::MAX_CLUSTERS_DEF;
    localparam int IDLE_MAX  = 2500000;
    localparam int ITEM_GOAL = 370;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    kmc_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    kmc_pkg::rsp_t rsp;
    logic cfg_we;
    logic [kmc_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [kmc_pkg::CFG_DATA_BITS-1:0] cfg_data;

    kmeans_cluster_4d_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] pt_coord [NPTS][4];
    logic [15:0] ctr_coord [NCTR][4];
    int unsigned pt_asg [NPTS];
    int unsigned pt_count;
    int unsigned seed_count;
    logic [3:0] k_reg;
    logic [7:0] iter_reg;

    kmc_pkg::req_t pending_reqs[$];
    kmc_pkg::rsp_t expected_rsps[$];
    int unsigned mismatches;
    int unsigned issued;
    int unsigned idle_cycles;
    bit req_taken;
    bit idling_on;
    int unsigned req_gap;
    int unsigned rsp_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic queue_rsp(input kmc_pkg::rsp_t o);
        expected_rsps.insert(expected_rsps.size(), o);
    endtask

    function automatic longint unsigned sq_dist(input int unsigned p, input int unsigned c);
        longint unsigned s;
        longint unsigned a;
        longint unsigned b;
        longint unsigned d;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            a = pt_coord[p][i];
            b = ctr_coord[c][i];
            d = (a > b) ? a - b : b - a;
            s += d * d;
        end
        return s;
    endfunction

    task automatic predict_cluster_run();
        int unsigned k;
        int unsigned lim;
        int unsigned passes;
        int unsigned best;
        bit changed;
        longint unsigned bestd;
        longint unsigned d;
        longint unsigned sums [NCTR][4];
        int unsigned cnts [NCTR];
        kmc_pkg::rsp_t o;
        k = 32'(k_reg);
        lim = (iter_reg == 0) ? 1 : 32'(iter_reg);
        if (k == 0) k = 1;
        if (k > NCTR) k = NCTR;
        o = '0;
        o.last = 1'b1;
        if (seed_count < k)
        begin
            o.status = kmc_pkg::ST_UNSEEDED;
            queue_rsp(o);
            return;
        end
        if (pt_count == 0)
        begin
            queue_rsp(o);
            return;
        end
        passes = 0;
        changed = 1;
        while (changed && passes < lim)
        begin
            passes++;
            changed = 0;
            for (int p = 0; p < pt_count; p++)
            begin
                best = 0;
                bestd = sq_dist(p, 0);
                for (int c = 1; c < k; c++)
                begin
                    d = sq_dist(p, c);
                    if (d < bestd)
                    begin
                        bestd = d;
                        best = c;
                    end
                end
                if (passes == 1 || pt_asg[p] != best) changed = 1;
                pt_asg[p] = best;
            end
            for (int c = 0; c < NCTR; c++)
            begin
                cnts[c] = 0;
                for (int i = 0; i < 4; i++) sums[c][i] = 0;
            end
            for (int p = 0; p < pt_count; p++)
            begin
                for (int i = 0; i < 4; i++) sums[pt_asg[p]][i] += pt_coord[p][i];
                cnts[pt_asg[p]]++;
            end
            for (int c = 0; c < k; c++)
                if (cnts[c] != 0)
                    for (int i = 0; i < 4; i++)
                        ctr_coord[c][i] = 16'(sums[c][i] / cnts[c]);
        end
        for (int p = 0; p < pt_count; p++)
        begin
            o = '0;
            o.point_index = 6'(p);
            o.group_id = 3'(pt_asg[p]);
            o.passes_used = 8'(passes);
            o.last = (p + 1 == pt_count);
            queue_rsp(o);
        end
    endtask

    task automatic predict_request(input kmc_pkg::req_t r);
        kmc_pkg::rsp_t o;
        o = '0;
        o.last = 1'b1;
        case (r.cmd)
            kmc_pkg::CMD_ADD:
            begin
                if (pt_count >= NPTS) o.status = kmc_pkg::ST_FULL;
                else
                begin
                    pt_coord[pt_count][0] = r.from_x;
                    pt_coord[pt_count][1] = r.from_y;
                    pt_coord[pt_count][2] = r.to_x;
                    pt_coord[pt_count][3] = r.to_y;
                    o.point_index = 6'(pt_count);
                    pt_count++;
                end
                queue_rsp(o);
            end
            kmc_pkg::CMD_SEED:
            begin
                o.point_index = r.seed_index;
                if (r.seed_index >= pt_count) o.status = kmc_pkg::ST_BAD_SEED;
                else if (seed_count < NCTR)
                begin
                    for (int i = 0; i < 4; i++)
                        ctr_coord[seed_count][i] = pt_coord[r.seed_index][i];
                    o.group_id = 3'(seed_count);
                    seed_count++;
                end
                queue_rsp(o);
            end
            kmc_pkg::CMD_RUN: predict_cluster_run();
            default:
            begin
                pt_count = 0;
                seed_count = 0;
                queue_rsp(o);
            end
        endcase
    endtask

    // monitor
    always @(posedge clk)
    begin
        kmc_pkg::rsp_t e;
        req_taken = 0;
        if (rst_n)
        begin
            idle_cycles++;
            if (req_valid && req_ready)
            begin
                req_taken = 1;
                idle_cycles = 0;
                predict_request(req);
            end
            if (rsp_valid && rsp_ready)
            begin
                idle_cycles = 0;
                if (expected_rsps.size() == 0) report_mismatch("unexpected result");
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.point_index !== e.point_index)
                        report_mismatch($sformatf("point_index %0d exp %0d",
                                                  rsp.point_index, e.point_index));
                    if (rsp.group_id !== e.group_id)
                        report_mismatch($sformatf("group_id %0d exp %0d (point %0d)",
                                                  rsp.group_id, e.group_id, e.point_index));
                    if (rsp.passes_used !== e.passes_used)
                        report_mismatch($sformatf("passes_used %0d exp %0d",
                                                  rsp.passes_used, e.passes_used));
                    if (rsp.status !== e.status)
                        report_mismatch($sformatf("status %0d exp %0d", rsp.status, e.status));
                    if (rsp.last !== e.last)
                        report_mismatch($sformatf("last %0d exp %0d", rsp.last, e.last));
                end
            end
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // request and result-ready driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_taken)
            begin
            end
            else if (req_gap > 0)
            begin
                req_gap--;
                req_valid <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                req_gap = $urandom_range(1, 17) - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else req_valid <= 1'b0;

            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rsp_gap = $urandom_range(1, 17) - 1;
                rsp_ready <= 1'b0;
            end
            else rsp_ready <= 1'b1;
        end
    end

    function automatic kmc_pkg::req_t rand_req(input logic [1:0] c);
        kmc_pkg::req_t r;
        r.cmd = c;
        r.from_x = 16'($urandom);
        r.from_y = 16'($urandom);
        r.to_x = 16'($urandom);
        r.to_y = 16'($urandom);
        r.seed_index = 6'($urandom);
        return r;
    endfunction

    task automatic push_req(input kmc_pkg::req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
        issued++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kmc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == kmc_pkg::REG_NUM_CLUSTERS) k_reg = val[3:0];
        else iter_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_coord(input logic [15:0] v);
        kmc_pkg::req_t r;
        r = rand_req(kmc_pkg::CMD_ADD);
        r.from_x = v;
        r.from_y = v;
        r.to_x = v;
        r.to_y = ~v;
        push_req(r);
    endtask

    task automatic push_seed(input logic [5:0] idx);
        kmc_pkg::req_t r;
        r = rand_req(kmc_pkg::CMD_SEED);
        r.seed_index = idx;
        push_req(r);
    endtask

    initial
    begin
        int unsigned npts;
        int unsigned nseed;
        int unsigned kk;
        kmc_pkg::req_t r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_taken = 0;
        req_gap = 0;
        rsp_gap = 0;
        idling_on = 1;
        mismatches = 0;
        issued = 0;
        idle_cycles = 0;
        pt_count = 0;
        seed_count = 0;
        k_reg = 4'd2;
        iter_reg = 8'd32;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, empty runs, bad seeds, extreme coordinates
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_seed(6'd0);
        push_seed(6'd63);
        push_coord(16'h0000);
        push_coord(16'hFFFF);
        push_coord(16'h0001);
        push_coord(16'hFFFE);
        push_seed(6'd0);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_seed(6'd1);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_req(rand_req(kmc_pkg::CMD_CLEAR));
        push_seed(6'd0);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_coord(16'h8000);
        push_seed(6'd0);
        push_seed(6'd0);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        drain();

        // num_clusters 0 acts as 1, max_iterations 0 as 1; seeds past 8 ignored
        write_reg(kmc_pkg::REG_NUM_CLUSTERS, 8'd0);
        write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'd0);
        for (int i = 0; i < 10; i++) push_seed(6'd0);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        drain();
        write_reg(kmc_pkg::REG_NUM_CLUSTERS, 8'd15);
        write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'd255);
        push_req(rand_req(kmc_pkg::CMD_RUN));
        push_req(rand_req(kmc_pkg::CMD_CLEAR));
        push_req(rand_req(kmc_pkg::CMD_RUN));
        drain();

        while (issued < ITEM_GOAL)
        begin
            kk = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 0 : 15) : $urandom_range(1, 8);
            write_reg(kmc_pkg::REG_NUM_CLUSTERS, 8'(kk));
            case ($urandom_range(0, 5))
                0: write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'd1);
                1: write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'd255);
                2: write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'($urandom_range(0, 255)));
                default: write_reg(kmc_pkg::REG_MAX_ITERATIONS, 8'($urandom_range(2, 40)));
            endcase
            if (issued > ITEM_GOAL - 60) idling_on = 0;
            push_req(rand_req(kmc_pkg::CMD_CLEAR));
            npts = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 12);
            for (int i = 0; i < npts; i++)
            begin
                r = rand_req(kmc_pkg::CMD_ADD);
                if ($urandom_range(0, 3) == 0)
                begin
                    // clustered small values to exercise ties and convergence
                    r.from_x = 16'($urandom_range(0, 7));
                    r.from_y = 16'($urandom_range(0, 7));
                    r.to_x = 16'($urandom_range(0, 7));
                    r.to_y = 16'($urandom_range(0, 7));
                end
                push_req(r);
            end
            nseed = $urandom_range(0, 9) == 0 ? $urandom_range(0, 10) : (kk == 0 ? 1 : kk);
            for (int i = 0; i < nseed; i++)
            begin
                if ($urandom_range(0, 7) == 0) push_seed(6'($urandom));
                else push_seed(6'($urandom_range(0, (npts > 64 ? 64 : npts) - 1)));
            end
            push_req(rand_req(kmc_pkg::CMD_RUN));
            if ($urandom_range(0, 2) == 0) push_req(rand_req(kmc_pkg::CMD_RUN));
            if ($urandom_range(0, 4) == 0) push_req(rand_req(2'($urandom_range(0, 3))));
            drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/kmc_pkg.sv
src/kmc_div.sv
src/kmeans_cluster_4d_top.sv
tb/kmeans_cluster_4d_top_test.sv
